[rtl/landmark_refcount_table_defines.svh]
// Assertion macros used by the landmark table datapath
`ifndef LANDMARK_REFCOUNT_TABLE_DEFINES_SVH
`define LANDMARK_REFCOUNT_TABLE_DEFINES_SVH

// implication checked on every edge outside reset
`define LRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication with the consequent checked in the next cycle
`define LRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/lrt_pkg.sv]
// Shared types and constants for the landmark table
`default_nettype none
package lrt_pkg;
  localparam logic [1:0] FUNC_ADD_AVG  = 2'd0;
  localparam logic [1:0] FUNC_ADD_CNT  = 2'd1;
  localparam logic [1:0] FUNC_REMOVE   = 2'd2;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam int unsigned DIV_STEPS    = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_DIVIDE,
    ST_WRITE,
    ST_OUTPUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic scan_clr;   // restart slot scan
    logic scan_step;  // compare one slot
    logic rd;         // read hit slot
    logic div_start;  // load dividers
    logic div_step;   // one quotient bit per axis
    logic wr;         // commit slot and build result
  } lrt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic need_div;
    logic div_done;
  } lrt_sts_t;
endpackage
`default_nettype wire

[rtl/lrt_ctrl.sv]
// Sequencer for lookup, divide and commit
`default_nettype none
module lrt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lrt_pkg::lrt_cmd_t   cmd_o,
  input  wire lrt_pkg::lrt_sts_t sts_i
);
  import lrt_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SEARCH;
      ST_SEARCH: if (sts_i.scan_done) state_d = ST_READ;
      ST_READ:   state_d = sts_i.need_div ? ST_DIVIDE : ST_WRITE;
      ST_DIVIDE: if (sts_i.div_done) state_d = ST_WRITE;
      ST_WRITE:  state_d = ST_OUTPUT;
      ST_OUTPUT: if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load     = in_valid_i;
        cmd_o.scan_clr = 1'b1;
      end
      ST_SEARCH: begin
        cmd_o.scan_step = 1'b1;
        // hit slot is settled once the scan is done
        cmd_o.rd        = sts_i.scan_done;
      end
      ST_READ:   cmd_o.div_start = sts_i.need_div;
      ST_DIVIDE: cmd_o.div_step = 1'b1;
      ST_WRITE:  cmd_o.wr = 1'b1;
      ST_OUTPUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[rtl/lrt_datapath.sv]
// Slot store, serial search and restoring dividers
`default_nettype none
`include "landmark_refcount_table_defines.svh"
module lrt_datapath #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lrt_pkg::lrt_cmd_t cmd_i,
  output lrt_pkg::lrt_sts_t      sts_o,
  input  wire logic [1:0]        func_i,
  input  wire logic signed [63:0] landmark_id_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  output logic                   found_o,
  output logic                   inserted_o,
  output logic                   freed_o,
  output logic                   full_drop_o,
  output logic [15:0]            obs_count_o,
  output logic signed [31:0]     mean_x_o,
  output logic signed [31:0]     mean_y_o,
  output logic signed [31:0]     mean_z_o
);
  import lrt_pkg::*;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] LAST = CW'(TABLE_DEPTH - 1);

  logic [TABLE_DEPTH-1:0] valid_q;
  logic [63:0] key_mem [TABLE_DEPTH];
  logic [15:0] cnt_mem [TABLE_DEPTH];
  logic [95:0] pos_mem [TABLE_DEPTH];

  logic [1:0]  func_q;
  logic [63:0] key_q;
  logic [95:0] obs_q;
  logic [CW-1:0] idx_q;
  logic        hit_q, free_ok_q;
  logic [AW-1:0] hit_slot_q, free_q;
  logic [63:0] key_rd_q;
  logic        key_rd_v_q;
  logic [AW-1:0] cmp_q;
  logic        scan_done_q;
  logic [15:0] cnt_q;
  logic [95:0] pos_q;
  logic [6:0]  div_cnt_q;

  // per axis restoring divide of |num| by c+1
  logic [63:0] mag_q [3];
  logic [63:0] quo_q [3];
  logic [16:0] rem_q [3];
  logic        neg_q [3];
  logic [16:0] dvs_q;
  logic signed [31:0] qres [3];

  logic addop;
  assign addop = (func_q == FUNC_ADD_AVG) || (func_q == FUNC_ADD_CNT);

  // scan: read key at idx, compare on next cycle
  always_ff @(posedge clk_i) begin
    key_rd_q <= key_mem[idx_q[AW-1:0]];
    cmp_q    <= idx_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; key_rd_v_q <= 1'b0; scan_done_q <= 1'b0;
      hit_q <= 1'b0; free_ok_q <= 1'b0; div_cnt_q <= '0;
    end else if (cmd_i.scan_clr) begin
      idx_q <= '0; key_rd_v_q <= 1'b0; scan_done_q <= 1'b0;
      hit_q <= 1'b0; free_ok_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (idx_q != CW'(TABLE_DEPTH)) idx_q <= idx_q + 1'b1;
      key_rd_v_q <= (idx_q != CW'(TABLE_DEPTH));
      if (key_rd_v_q) begin
        if (!hit_q && valid_q[cmp_q] && key_rd_q == key_q) hit_q <= 1'b1;
        if (!free_ok_q && !valid_q[cmp_q]) free_ok_q <= 1'b1;
        if (cmp_q == LAST[AW-1:0]) scan_done_q <= 1'b1;
      end
    end else if (cmd_i.div_start) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q  <= landmark_id_i;
      obs_q  <= {pos_z_i, pos_y_i, pos_x_i};
    end
    if (cmd_i.scan_step && key_rd_v_q) begin
      if (!hit_q && valid_q[cmp_q] && key_rd_q == key_q) hit_slot_q <= cmp_q;
      if (!free_ok_q && !valid_q[cmp_q]) free_q <= cmp_q;
    end
    if (cmd_i.rd) begin
      cnt_q <= cnt_mem[hit_slot_q];
      pos_q <= pos_mem[hit_slot_q];
    end
  end

  assign sts_o.scan_done = scan_done_q;
  assign sts_o.need_div  = hit_q && (func_q == FUNC_ADD_AVG);
  assign sts_o.div_done  = (div_cnt_q == 7'(DIV_STEPS - 1));

  // dividers: operands taken from the read registers
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [63:0] num;
    logic [17:0] trial;
    assign num = $signed({1'b0, cnt_q}) *
                 $signed(pos_q[a*32 +: 32])
                 + 64'($signed(obs_q[a*32 +: 32]));
    assign trial = {rem_q[a], mag_q[a][63]};
    always_ff @(posedge clk_i) begin
      if (cmd_i.div_start) begin
        neg_q[a] <= num[63];
        mag_q[a] <= num[63] ? (~num + 64'd1) : num;
        quo_q[a] <= '0;
        rem_q[a] <= '0;
      end else if (cmd_i.div_step) begin
        mag_q[a] <= {mag_q[a][62:0], 1'b0};
        if (trial >= {1'b0, dvs_q}) begin
          rem_q[a] <= 17'(trial - {1'b0, dvs_q});
          quo_q[a] <= {quo_q[a][62:0], 1'b1};
        end else begin
          rem_q[a] <= trial[16:0];
          quo_q[a] <= {quo_q[a][62:0], 1'b0};
        end
      end
    end
    assign qres[a] = neg_q[a] ? 32'(~quo_q[a] + 64'd1) : quo_q[a][31:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) dvs_q <= {1'b0, cnt_q} + 17'd1;
  end

  logic [15:0] cnt_inc, cnt_dec;
  assign cnt_inc = (cnt_q == COUNT_MAX) ? COUNT_MAX : cnt_q + 16'd1;
  assign cnt_dec = (cnt_q == 16'd0) ? 16'd0 : cnt_q - 16'd1;

  // commit and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.wr) begin
      if (addop && !hit_q && free_ok_q) valid_q[free_q] <= 1'b1;
      if (func_q == FUNC_REMOVE && hit_q && cnt_dec == 16'd0) valid_q[hit_slot_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      found_o <= hit_q;
      inserted_o <= 1'b0; freed_o <= 1'b0; full_drop_o <= 1'b0;
      obs_count_o <= '0;
      {mean_z_o, mean_y_o, mean_x_o} <= '0;
      if (addop && hit_q) begin
        cnt_mem[hit_slot_q] <= cnt_inc;
        obs_count_o <= cnt_inc;
        if (func_q == FUNC_ADD_AVG) begin
          pos_mem[hit_slot_q] <= {qres[2], qres[1], qres[0]};
          {mean_z_o, mean_y_o, mean_x_o} <= {qres[2], qres[1], qres[0]};
        end else begin
          {mean_z_o, mean_y_o, mean_x_o} <= pos_q;
        end
      end else if (addop) begin
        if (free_ok_q) begin
          key_mem[free_q] <= key_q;
          cnt_mem[free_q] <= 16'd1;
          pos_mem[free_q] <= obs_q;
          inserted_o <= 1'b1;
          obs_count_o <= 16'd1;
          {mean_z_o, mean_y_o, mean_x_o} <= obs_q;
        end else begin
          full_drop_o <= 1'b1;
        end
      end else if (func_q == FUNC_REMOVE) begin
        if (hit_q) begin
          cnt_mem[hit_slot_q] <= cnt_dec;
          if (cnt_dec == 16'd0) freed_o <= 1'b1;
          else begin
            obs_count_o <= cnt_dec;
            {mean_z_o, mean_y_o, mean_x_o} <= pos_q;
          end
        end
      end else if (hit_q) begin
        obs_count_o <= cnt_q;
        {mean_z_o, mean_y_o, mean_x_o} <= pos_q;
      end
    end
  end

  `LRT_ASSERT_IMP(a_div_excl, clk_i, rst_ni, cmd_i.div_step, !cmd_i.wr && !cmd_i.scan_step)
  `LRT_ASSERT_NEXT(a_ins_valid, clk_i, rst_ni,
    cmd_i.wr && addop && !hit_q && free_ok_q, valid_q[free_q])
  `LRT_ASSERT_NEXT(a_one_flag, clk_i, rst_ni, cmd_i.wr, $onehot0({inserted_o, freed_o, full_drop_o}))
endmodule
`default_nettype wire

[rtl/landmark_refcount_table.sv]
// Top level of the reference-counted landmark table
// channel | dir | fields
// in      | in  | func, landmark_id, pos_x, pos_y, pos_z
// out     | out | found, inserted, freed, full_drop, obs_count, mean_x/y/z
// One beat at a time: an accept state, then a serial key search over the key
// memory read port (hit slot read at its end), a setup state, a bit-serial
// divide (three axes in parallel) only on an averaging add with a hit, then a
// commit state before the result shows.
// Reset clears all valid bits at once; no clearing pass.
// The result holds until taken; a new beat is taken only once it has gone.
`default_nettype none
module landmark_refcount_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         func_i,
  input  wire logic signed [63:0] landmark_id_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    found_o,
  output logic                    inserted_o,
  output logic                    freed_o,
  output logic                    full_drop_o,
  output logic [15:0]             obs_count_o,
  output logic signed [31:0]      mean_x_o,
  output logic signed [31:0]      mean_y_o,
  output logic signed [31:0]      mean_z_o
);
  import lrt_pkg::*;
  lrt_cmd_t cmd;
  lrt_sts_t sts;

  lrt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  lrt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .func_i, .landmark_id_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .found_o, .inserted_o, .freed_o, .full_drop_o, .obs_count_o,
    .mean_x_o, .mean_y_o, .mean_z_o
  );
endmodule
`default_nettype wire
